// ===== hw/rtl/xs128_pkg.sv =====
// Shared types and constants for the xoroshiro128+ generator.
`default_nettype none
package xs128_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;

    // command queue between front and back
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = 1;
    localparam int CMD_CNT_W = 2;

    localparam logic MODE_SEED = 1'b0;
    localparam logic MODE_NEXT = 1'b1;

    localparam logic [WORD_W-1:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B = 64'h94d049bb133111eb;
    localparam logic [WORD_W-1:0] FNV_PRIME = 64'd1099511628211;

    localparam int MIX_SH_A = 30;
    localparam int MIX_SH_B = 27;
    localparam int MIX_SH_C = 31;

    localparam int ROT_A = 55;
    localparam int SHL_B = 14;
    localparam int ROT_C = 36;

    typedef struct packed {
        logic              mode;
        logic [WORD_W-1:0] seed;
    } cmd_t;

    typedef struct packed {
        logic              run;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] result;
    } mul_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/xs128_front.sv =====
// Front end: two-entry command queue that accepts and stores input beats.
`default_nettype none
module xs128_front
    import xs128_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              mode,
    input  wire logic [WORD_W-1:0] seed_value,
    output logic                   cmd_valid,
    output cmd_t                   cmd,
    input  wire logic              cmd_take
);

    cmd_t                 mem_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_CNT_W-1:0] count_reg;
    logic                 wr_en;
    logic                 rd_en;

    assign full      = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = mem_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_take && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg].mode <= mode;
            mem_reg[wr_ptr_reg].seed <= seed_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/xs128_mul.sv =====
// 64x64 modulo-2^64 multiplier built from one 32x32 multiplier reused across its phases.
`default_nettype none
module xs128_mul
    import xs128_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    logic [1:0]        phase_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [HALF_W-1:0] op_x;
    logic [HALF_W-1:0] op_y;
    logic [WORD_W-1:0] prod_shifted;

    // phase 0: lo*lo, phase 1: lo*hi, phase 2: hi*lo, phase 3: final sum
    always_comb
    begin
        case (phase_reg)
            2'd0:
            begin
                op_x = req.a[HALF_W-1:0];
                op_y = req.b[HALF_W-1:0];
            end
            2'd1:
            begin
                op_x = req.a[HALF_W-1:0];
                op_y = req.b[WORD_W-1:HALF_W];
            end
            default:
            begin
                op_x = req.a[WORD_W-1:HALF_W];
                op_y = req.b[HALF_W-1:0];
            end
        endcase
    end

    assign prod_shifted = {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
    assign rsp.done     = req.run && (phase_reg == 2'd3);
    assign rsp.result   = acc_reg + prod_shifted;

    always_ff @(posedge clk)
    begin
        prod_reg <= WORD_W'(op_x) * WORD_W'(op_y);
        case (phase_reg)
            2'd1:    acc_reg <= prod_reg;
            2'd2:    acc_reg <= acc_reg + prod_shifted;
            default: acc_reg <= acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (req.run)
        begin
            phase_reg <= phase_reg + 1'b1;
        end
        else
        begin
            phase_reg <= '0;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/xs128_back.sv =====
// Back end: generator state, seeding sequencer and result register.
`default_nettype none
module xs128_back
    import xs128_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire cmd_t              cmd,
    output logic                   cmd_take,
    output logic                   empty,
    input  wire logic              pop,
    output logic [WORD_W-1:0]      random_value
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_MUL_F
    } state_t;

    state_t            state_reg;
    logic [WORD_W-1:0] low_reg;
    logic [WORD_W-1:0] high_reg;
    logic [WORD_W-1:0] seed_reg;
    logic [WORD_W-1:0] v_reg;
    logic              pass_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] random_reg;

    logic [WORD_W-1:0] mix_t;
    logic [WORD_W-1:0] low_next;
    logic [WORD_W-1:0] high_next;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [WORD_W-1:0] r_f;
    logic              out_free;
    logic              step_fire;
    mul_req_t          mul_req;
    mul_rsp_t          mul_rsp;

    xs128_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign empty        = !out_valid_reg;
    assign random_value = random_reg;
    assign out_free     = !out_valid_reg || pop;

    assign cmd_take = (state_reg == S_IDLE) && cmd_valid
                      && ((cmd.mode == MODE_SEED) || out_free);
    assign step_fire = cmd_take && (cmd.mode == MODE_NEXT);

    // one generator step
    assign mix_t     = high_reg ^ low_reg;
    assign low_next  = ((low_reg << ROT_A) | (low_reg >> (WORD_W - ROT_A)))
                       ^ mix_t ^ (mix_t << SHL_B);
    assign high_next = (mix_t << ROT_C) | (mix_t >> (WORD_W - ROT_C));

    // post-multiply steps of the mix hash
    assign r_a = mul_rsp.result ^ (mul_rsp.result >> MIX_SH_B);
    assign r_b = mul_rsp.result ^ (mul_rsp.result >> MIX_SH_C);
    assign r_f = (low_reg ^ mul_rsp.result)
                 ^ ((low_reg ^ mul_rsp.result) >> MIX_SH_A);

    always_comb
    begin
        mul_req.run = state_reg inside {S_MUL_A, S_MUL_B, S_MUL_F};
        mul_req.a   = (state_reg == S_MUL_F) ? seed_reg : v_reg;
        case (state_reg)
            S_MUL_B: mul_req.b = MIX_MUL_B;
            S_MUL_F: mul_req.b = FNV_PRIME;
            default: mul_req.b = MIX_MUL_A;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
            low_reg       <= '0;
            high_reg      <= '0;
            seed_reg      <= '0;
            v_reg         <= '0;
            pass_reg      <= 1'b0;
            random_reg    <= '0;
        end
        else
        begin
            // a new step refills the result register in the cycle it is popped
            if (step_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT:
                begin
                    // reset state is the state after seeding zero
                    seed_reg  <= '0;
                    v_reg     <= '0;
                    pass_reg  <= 1'b0;
                    state_reg <= S_MUL_A;
                end
                S_IDLE:
                begin
                    if (step_fire)
                    begin
                        random_reg <= low_reg + high_reg;
                        low_reg    <= low_next;
                        high_reg   <= high_next;
                    end
                    else if (cmd_take)
                    begin
                        seed_reg  <= cmd.seed;
                        v_reg     <= cmd.seed ^ (cmd.seed >> MIX_SH_A);
                        pass_reg  <= 1'b0;
                        state_reg <= S_MUL_A;
                    end
                end
                S_MUL_A:
                begin
                    if (mul_rsp.done)
                    begin
                        v_reg     <= r_a;
                        state_reg <= S_MUL_B;
                    end
                end
                S_MUL_B:
                begin
                    if (mul_rsp.done)
                    begin
                        if (!pass_reg)
                        begin
                            low_reg   <= r_b | WORD_W'(1);
                            state_reg <= S_MUL_F;
                        end
                        else
                        begin
                            high_reg  <= r_b;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_MUL_F:
                begin
                    if (mul_rsp.done)
                    begin
                        v_reg     <= r_f;
                        pass_reg  <= 1'b1;
                        state_reg <= S_MUL_A;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/xoroshiro128plus_generator.sv =====
// Top level of the xoroshiro128+ (55/14/36) random generator.
//
// Input channel (push/full): one beat carries mode and seed_value. mode 1
// asks for the next random value, mode 0 loads a new seed and returns nothing.
// Output channel (empty/pop): random_value is valid while empty is low.
// Beats land in a two-entry command queue; the back end drains it.
// A next beat leaves the back end idle, so a steady stream of next beats
// runs at one per cycle while the receiver pops; empty falls in the cycle after the beat is taken.
// A seed beat runs five 64-bit multiplies on one shared 32x32 multiplier,
// one after another; later beats wait behind it.
// Reset runs the same seeding sequence with a seed of zero;
// up to two beats are queued meanwhile, then full rises.
// When the receiver stalls, the single result register holds its beat,
// the queue fills behind it, and full rises; nothing is dropped.
`default_nettype none
module xoroshiro128plus_generator
    import xs128_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic              mode,
    input  wire logic [WORD_W-1:0] seed_value,
    output logic                   empty,
    input  wire logic              pop,
    output logic [WORD_W-1:0]      random_value
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;

    // front: queue input beats
    xs128_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .mode       (mode),
        .seed_value (seed_value),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take)
    );

    // back: state update, seeding, result register
    xs128_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (cmd_take),
        .empty        (empty),
        .pop          (pop),
        .random_value (random_value)
    );

endmodule
`default_nettype wire
